### rtl/pph_pkg.sv
// ============================================================================
// pph_pkg
// Shared constants and the arctangent table for the point pair heading block.
// ============================================================================
package pph_pkg;

    localparam int COORD_WIDTH_DEF  = 16;
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int TABLE_LEN        = 24;

    // Vector datapath width and the scaled magnitude that the guard bits target.
    localparam int XY_W       = 64;
    localparam int SCALE_BITS = 58;

    // Angle accumulator: radians with 30 fraction bits.
    localparam int ACC_W = 34;
    localparam int ACC_FRAC = 30;

    localparam int HEAD_W     = 17;
    localparam int HEAD_FRAC  = 13;
    localparam int OUT_DATA_W = ((HEAD_W + 7) / 8) * 8;

    localparam logic signed [HEAD_W-1:0] HALF_PI  = 17'sd12868;
    localparam logic signed [HEAD_W-1:0] OUT_MIN  = -17'sd12868;
    localparam logic signed [HEAD_W-1:0] OUT_MAX  = 17'sd38604;
    localparam logic signed [ACC_W-1:0]  ANGLE_HALF_PI = 34'sd1686629713;
    localparam logic signed [ACC_W-1:0]  ROUND_HALF =
        ACC_W'(64'sd1 <<< (ACC_FRAC - HEAD_FRAC - 1));

    typedef struct packed {
        logic coincide;
        logic dz_zero;
        logic dx_pos;
    } pph_flags_t;

    function automatic logic signed [ACC_W-1:0] atan_entry(input int idx);
        logic signed [ACC_W-1:0] val;
        unique case (idx)
            0:       val = 34'sh3243F6A8;
            1:       val = 34'sh1DAC6705;
            2:       val = 34'sh0FADBAFC;
            3:       val = 34'sh07F56EA6;
            4:       val = 34'sh03FEAB76;
            5:       val = 34'sh01FFD55B;
            6:       val = 34'sh00FFFAAA;
            7:       val = 34'sh007FFF55;
            8:       val = 34'sh003FFFEA;
            9:       val = 34'sh001FFFFD;
            10:      val = 34'sh000FFFFF;
            11:      val = 34'sh0007FFFF;
            12:      val = 34'sh0003FFFF;
            13:      val = 34'sh0001FFFF;
            14:      val = 34'sh0000FFFF;
            15:      val = 34'sh00007FFF;
            16:      val = 34'sh00003FFF;
            17:      val = 34'sh00001FFF;
            18:      val = 34'sh00000FFF;
            19:      val = 34'sh000007FF;
            20:      val = 34'sh000003FF;
            21:      val = 34'sh000001FF;
            22:      val = 34'sh000000FF;
            23:      val = 34'sh0000007F;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

### rtl/point_pair_heading.sv
// ============================================================================
// point_pair_heading
// Heading from a start point to an end point, pi/2 - atan2(-dz, dx), by a
// fully pipelined vectoring CORDIC.
// ============================================================================
// The block takes one point pair per clock cycle while the output is not
// held and returns one heading per pair, in order. CORDIC_STEPS is capped at
// the 24 entries of the arctangent table. In the pipeline, one stage forms
// the differences, one turns the vector into the right half plane, one
// stage runs each CORDIC iteration, and the output register rounds and
// saturates. Empty stages close up while the output is held, so new pairs
// are taken until every stage is full.
module point_pair_heading
    import pph_pkg::*;
#(
    parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
)
(
    input  logic clk,
    input  logic rst_n,

    input  logic                                     s_tvalid,
    output logic                                     s_tready,
    // start_x, start_z, end_x, end_z from the lowest bit up, zero padded.
    input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]       s_tdata,

    output logic                                     m_tvalid,
    input  logic                                     m_tready,
    // heading_rad in the lowest bits, zero padded.
    output logic [OUT_DATA_W-1:0]                    m_tdata,
    // points_coincide.
    output logic                                     m_tuser
);

    localparam int N     = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int LAST  = N + 2;
    localparam int GUARD = SCALE_BITS - COORD_WIDTH;
    localparam int DW    = COORD_WIDTH + 1;

    logic [LAST:0]   valid_reg;
    logic [LAST+1:0] ready;
    pph_flags_t      flags_reg [0:LAST-1];

    logic signed [DW-1:0] dx_reg;
    logic signed [DW-1:0] dz_reg;

    logic signed [XY_W-1:0]  x_reg   [1:N+1];
    logic signed [XY_W-1:0]  y_reg   [1:N+1];
    logic signed [ACC_W-1:0] acc_reg [1:N+1];

    logic signed [HEAD_W-1:0] head_reg;
    logic                     coin_reg;

    always_comb
    begin
        ready[LAST+1] = m_tready;
        for (int k = LAST; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    assign s_tready = ready[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (ready[0])
            begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = LAST; k >= 1; k--)
            begin
                if (ready[k])
                begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: coordinate differences and special case flags.
    logic signed [COORD_WIDTH-1:0] sx, sz, ex, ez;
    logic signed [DW-1:0]          dx_next, dz_next;
    pph_flags_t                    flags_next;

    always_comb
    begin
        sx = signed'(s_tdata[0*COORD_WIDTH +: COORD_WIDTH]);
        sz = signed'(s_tdata[1*COORD_WIDTH +: COORD_WIDTH]);
        ex = signed'(s_tdata[2*COORD_WIDTH +: COORD_WIDTH]);
        ez = signed'(s_tdata[3*COORD_WIDTH +: COORD_WIDTH]);
        dx_next = DW'(ex) - DW'(sx);
        dz_next = DW'(ez) - DW'(sz);
        flags_next.dz_zero  = (dz_next == '0);
        flags_next.coincide = (dz_next == '0) && (dx_next == '0);
        flags_next.dx_pos   = !dx_next[DW-1] && (dx_next != '0);
    end

    always_ff @(posedge clk)
    begin
        if (ready[0] && s_tvalid)
        begin
            dx_reg       <= dx_next;
            dz_reg       <= dz_next;
            flags_reg[0] <= flags_next;
        end
    end

    // Stage 1: scale and turn into the right half plane.
    logic signed [XY_W-1:0]  dx_w, ny_w;
    logic signed [XY_W-1:0]  x1_next, y1_next;
    logic signed [ACC_W-1:0] acc1_next;

    always_comb
    begin
        dx_w = XY_W'(dx_reg) <<< GUARD;
        ny_w = -(XY_W'(dz_reg) <<< GUARD);
        if (dx_w[XY_W-1])
        begin
            if (!ny_w[XY_W-1] && (ny_w != '0))
            begin
                x1_next   = ny_w;
                y1_next   = -dx_w;
                acc1_next = ANGLE_HALF_PI;
            end
            else
            begin
                x1_next   = -ny_w;
                y1_next   = dx_w;
                acc1_next = -ANGLE_HALF_PI;
            end
        end
        else
        begin
            x1_next   = dx_w;
            y1_next   = ny_w;
            acc1_next = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[1] && valid_reg[0])
        begin
            x_reg[1]     <= x1_next;
            y_reg[1]     <= y1_next;
            acc_reg[1]   <= acc1_next;
            flags_reg[1] <= flags_reg[0];
        end
    end

    // Stages 2 .. N+1: one CORDIC iteration each.
    for (genvar i = 0; i < N; i++)
    begin : g_iter
        logic signed [XY_W-1:0] xs, ys;
        logic                   y_pos;

        assign xs    = x_reg[i+1] >>> i;
        assign ys    = y_reg[i+1] >>> i;
        assign y_pos = !y_reg[i+1][XY_W-1] && (y_reg[i+1] != '0);

        always_ff @(posedge clk)
        begin
            if (ready[i+2] && valid_reg[i+1])
            begin
                flags_reg[i+2] <= flags_reg[i+1];
                if (y_pos)
                begin
                    x_reg[i+2]   <= x_reg[i+1] + ys;
                    y_reg[i+2]   <= y_reg[i+1] - xs;
                    acc_reg[i+2] <= acc_reg[i+1] + atan_entry(i);
                end
                else
                begin
                    x_reg[i+2]   <= x_reg[i+1] - ys;
                    y_reg[i+2]   <= y_reg[i+1] + xs;
                    acc_reg[i+2] <= acc_reg[i+1] - atan_entry(i);
                end
            end
        end
    end

    // Output stage: rounding, saturation and special cases.
    pph_flags_t               fl;
    logic signed [ACC_W-1:0]  fine;
    logic signed [ACC_W-1:0]  rounded;
    logic signed [HEAD_W-1:0] coarse;
    logic signed [HEAD_W-1:0] head_next;

    always_comb
    begin
        fl      = flags_reg[LAST-1];
        fine    = ANGLE_HALF_PI - acc_reg[N+1];
        rounded = (fine + ROUND_HALF) >>> (ACC_FRAC - HEAD_FRAC);
        coarse  = rounded[HEAD_W-1:0];
        priority if (fl.coincide)
        begin
            head_next = '0;
        end
        else if (fl.dz_zero)
        begin
            head_next = fl.dx_pos ? HALF_PI : -HALF_PI;
        end
        else if (coarse < OUT_MIN)
        begin
            head_next = OUT_MIN;
        end
        else if (coarse > OUT_MAX)
        begin
            head_next = OUT_MAX;
        end
        else
        begin
            head_next = coarse;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready[LAST] && valid_reg[LAST-1])
        begin
            head_reg <= head_next;
            coin_reg <= fl.coincide;
        end
    end

    assign m_tvalid = valid_reg[LAST];
    assign m_tdata  = {{(OUT_DATA_W-HEAD_W){1'b0}}, head_reg};
    assign m_tuser  = coin_reg;

    a_coincide_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> (head_reg == '0))
        else $error("Coincident points must give a zero heading.");

    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (head_reg >= OUT_MIN) && (head_reg <= OUT_MAX))
        else $error("Heading outside its range.");

    a_full_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (&valid_reg) && !m_tready)
        else $error("Input blocked while the pipeline has an empty stage.");

endmodule
